FILE: hw/rtl/yuv420_test_pattern_generator_defines.svh
// Assertion helpers for the YUV 4:2:0 test pattern generator.
// Each macro expects clk and rst in scope; checks are off while in reset.
`ifndef YUV420_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define YUV420_TEST_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define YTPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define YTPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ytpg_pkg.sv
package ytpg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int BAR_BITS       = 3;
  localparam int OFFSET_BITS    = 9;
  localparam int BW_REG_BITS    = 10;
  localparam int FH_REG_BITS    = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_IDX_BITS   = 1;
  localparam int SAMPLE_BITS    = 8;

  localparam logic [BW_REG_BITS-1:0] BAR_WIDTH_RST    = 10'd80;
  localparam logic [FH_REG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BAR_WIDTH    = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] u;
    logic [SAMPLE_BITS-1:0] v;
  } colour_t;

  // Black, red, green, blue, yellow, cyan, magenta, white.
  localparam colour_t BAR_COLOUR [8] = '{
    '{8'd0,   8'd128, 8'd128},
    '{8'd76,  8'd84,  8'd255},
    '{8'd149, 8'd43,  8'd21},
    '{8'd29,  8'd255, 8'd107},
    '{8'd225, 8'd0,   8'd148},
    '{8'd178, 8'd171, 8'd0},
    '{8'd105, 8'd212, 8'd234},
    '{8'd255, 8'd128, 8'd128}
  };

endpackage

FILE: hw/rtl/yuv420_test_pattern_generator.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------------
// request   | in        | req_valid/req_stall  | pixel_request
// pixel     | out       | pix_valid/pix_stall  | column, line, luma, chroma_blue,
//           |           |                      | chroma_red, frame_end
// config    | in        | cfg_write            | cfg_index, cfg_data
//
// One request transfer per cycle while req_stall is low; pixels leave the result register.
// The pixel is worked out combinationally from the raster counters into the result register.
// A skid register behind the result register takes one more pixel while the output is stalled;
// req_stall rises only while that skid entry is occupied.
// Synchronous active-high reset: raster position and frame counter cleared,
// bar_width back to 80 and frame_height back to 480.
`include "yuv420_test_pattern_generator_defines.svh"

module yuv420_test_pattern_generator
  import ytpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // request channel
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic                     pixel_request,
  // pixel channel
  output logic                     pix_valid,
  input  logic                     pix_stall,
  output logic [COORD_BITS-1:0]    column,
  output logic [COORD_BITS-1:0]    line,
  output logic [SAMPLE_BITS-1:0]   luma,
  output logic [SAMPLE_BITS-1:0]   chroma_blue,
  output logic [SAMPLE_BITS-1:0]   chroma_red,
  output logic                     frame_end
);

  // Working width: holds the registers and 2^COORD_BITS without overflow.
  localparam int WIDE = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;

  typedef struct packed {
    logic [COORD_BITS-1:0]  column;
    logic [COORD_BITS-1:0]  line;
    logic [SAMPLE_BITS-1:0] luma;
    logic [SAMPLE_BITS-1:0] chroma_blue;
    logic [SAMPLE_BITS-1:0] chroma_red;
    logic                   frame_end;
  } pixel_t;

  // Configuration registers
  logic [BW_REG_BITS-1:0] bar_width;
  logic [FH_REG_BITS-1:0] frame_height;

  // Raster state
  logic [COORD_BITS-1:0]  col_count,   col_count_next;
  logic [COORD_BITS-1:0]  row_count,   row_count_next;
  logic [BAR_BITS-1:0]    bar_index,   bar_index_next;
  logic [OFFSET_BITS-1:0] bar_offset,  bar_offset_next;
  logic [SAMPLE_BITS-1:0] frame_count, frame_count_next;

  // Result register and skid entry
  pixel_t result, skid;
  logic   result_valid, skid_valid;
  pixel_t pix_next;

  logic req_xfer, produce, out_free;

  assign req_stall = skid_valid;
  assign req_xfer  = req_valid && !req_stall;
  assign produce   = req_xfer && pixel_request;
  assign out_free  = !result_valid || !pix_stall;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_width    <= BAR_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAR_WIDTH:    bar_width    <= cfg_data[BW_REG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective geometry: zero treated as one, saturated to the coordinate range
  // ---------------------------------------------------------------------------
  logic [WIDE-1:0] bw_raw, bw_lim, bw_eff, frame_w;
  logic [WIDE-1:0] fh_raw, fh_lim, fh_eff;

  always_comb begin
    bw_raw = WIDE'(bar_width);
    bw_lim = WIDE'(1) << (COORD_BITS - 3);
    if (bw_raw == '0) begin
      bw_eff = WIDE'(1);
    end else if (bw_raw > bw_lim) begin
      bw_eff = bw_lim;
    end else begin
      bw_eff = bw_raw;
    end
    frame_w = bw_eff << 3;

    fh_raw = WIDE'(frame_height);
    fh_lim = WIDE'(1) << COORD_BITS;
    if (fh_raw == '0) begin
      fh_eff = WIDE'(1);
    end else if (fh_raw > fh_lim) begin
      fh_eff = fh_lim;
    end else begin
      fh_eff = fh_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel datapath
  // ---------------------------------------------------------------------------
  logic [WIDE-1:0]        x, y, cx, cy;
  logic [SAMPLE_BITS-1:0] f, f2, f3, f5;
  logic                   last_off, last_col, last_row, frame_start;
  logic [BAR_BITS-1:0]    cbar;
  logic                   luma_ramp, chroma_ramp;

  always_comb begin
    x  = WIDE'(col_count);
    y  = WIDE'(row_count);
    cx = x >> 1;
    cy = y >> 1;

    // Frame counter steps before the first pixel of every frame
    frame_start = (col_count == '0) && (row_count == '0);
    f  = frame_start ? frame_count + 8'd1 : frame_count;
    f2 = f << 1;
    f3 = f2 + f;
    f5 = (f << 2) + f;

    last_off = (WIDE'(bar_offset) + WIDE'(1)) >= bw_eff;
    last_col = (x + WIDE'(1)) >= frame_w;
    last_row = (y + WIDE'(1)) >= fh_eff;

    // Chroma of a cell follows its odd column, which may sit in the next bar
    cbar = (!x[0] && last_off) ? bar_index + BAR_BITS'(1) : bar_index;

    luma_ramp   = (y >= (fh_eff >> 1)) && (x >= (frame_w >> 1));
    chroma_ramp = (cy >= (fh_eff >> 2)) && (cy < (fh_eff >> 1)) &&
                  (cx >= (frame_w >> 2)) && (cx < (frame_w >> 1));

    pix_next.column = col_count;
    pix_next.line   = row_count;
    pix_next.luma   = luma_ramp ? x[SAMPLE_BITS-1:0] + y[SAMPLE_BITS-1:0] + f5
                                : BAR_COLOUR[bar_index].y;
    pix_next.chroma_blue = chroma_ramp ? cx[SAMPLE_BITS-1:0] + cy[SAMPLE_BITS-1:0] + f2
                                       : BAR_COLOUR[cbar].u;
    pix_next.chroma_red  = chroma_ramp ? cx[SAMPLE_BITS-1:0] + cy[SAMPLE_BITS-1:0] + f3
                                       : BAR_COLOUR[cbar].v;
    pix_next.frame_end = last_col && last_row;

    // Raster advance
    frame_count_next = f;
    if (last_col) begin
      col_count_next  = '0;
      bar_index_next  = '0;
      bar_offset_next = '0;
      row_count_next  = last_row ? '0 : row_count + COORD_BITS'(1);
    end else begin
      col_count_next = col_count + COORD_BITS'(1);
      row_count_next = row_count;
      if (last_off) begin
        bar_offset_next = '0;
        bar_index_next  = bar_index + BAR_BITS'(1);
      end else begin
        bar_offset_next = bar_offset + OFFSET_BITS'(1);
        bar_index_next  = bar_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      bar_index   <= '0;
      bar_offset  <= '0;
      frame_count <= '0;
    end else if (produce) begin
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      bar_index   <= bar_index_next;
      bar_offset  <= bar_offset_next;
      frame_count <= frame_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register with skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      // skid drains first; no new pixel can arrive while it is full
      result_valid <= skid_valid || produce;
      skid_valid   <= 1'b0;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result <= skid_valid ? skid : pix_next;
    end else if (produce) begin
      skid <= pix_next;
    end
  end

  assign pix_valid   = result_valid;
  assign column      = result.column;
  assign line        = result.line;
  assign luma        = result.luma;
  assign chroma_blue = result.chroma_blue;
  assign chroma_red  = result.chroma_red;
  assign frame_end   = result.frame_end;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `YTPG_ASSERT_NOW(a_skid_behind_result, skid_valid, result_valid, "skid full with result empty")
  `YTPG_ASSERT_NOW(a_bar_at_line_start, col_count == '0, (bar_index == '0) && (bar_offset == '0), "bar state not cleared at line start")
  `YTPG_ASSERT_NXT(a_frame_step, produce && frame_start, frame_count == $past(frame_count) + 8'd1, "frame counter missed a frame start")
  `YTPG_ASSERT_NXT(a_stall_catches, result_valid && pix_stall && produce, skid_valid && result_valid, "pixel lost under output stall")

endmodule
